[rtl/euler_to_homogeneous_transform_defines.svh]
// Assertion macros shared by the transform pipeline.
// Compiled to nothing when SYNTHESIS is defined.
`ifndef EULER_TO_HOMOGENEOUS_TRANSFORM_DEFINES_SVH
`define EULER_TO_HOMOGENEOUS_TRANSFORM_DEFINES_SVH
`ifndef SYNTHESIS
`define ETHTF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("check failed");
`define ETHTF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("check failed");
`else
`define ETHTF_ASSERT(lbl, clk, rst, prop)
`define ETHTF_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/ethtf_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and rounding helpers for the transform pipeline.
// No dependencies.
package ethtf_pkg;

  localparam int CORDIC_ITERS = 30;
  localparam int ZW = 34;

  localparam logic signed [ZW-1:0] CORDIC_GAIN    = 34'sd652032874;
  localparam logic signed [ZW-1:0] CORDIC_QUARTER = 34'sd1073741824;
  localparam logic signed [ZW-1:0] CORDIC_HALF    = 34'sd2147483648;

  typedef struct packed {
    logic signed [2:0][ZW-1:0] x;
    logic signed [2:0][ZW-1:0] y;
    logic [2:0]                flip;
    logic signed [31:0]        trans_x;
    logic signed [31:0]        trans_y;
    logic signed [31:0]        trans_z;
  } cordic_res_t;

  function automatic logic signed [ZW-1:0] atan_q32(input int idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0: r = 34'sd536870912;   1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;    4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;    7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;     10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;     13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;      16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;       19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;        22: r = 34'sd163;       23: r = 34'sd81;
      24: r = 34'sd41;         25: r = 34'sd20;        26: r = 34'sd10;
      27: r = 34'sd5;          28: r = 34'sd3;         29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round to nearest, ties away from zero.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
    logic        neg;
    logic [63:0] m;
    neg = v[63];
    m = neg ? 64'(-v) : 64'(v);
    if (sh != 0) begin
      m = (m + (64'd1 << (sh - 1))) >> sh;
    end
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] sat_coef(input logic signed [63:0] v,
                                                  input int unsigned f);
    logic signed [63:0] one;
    one = $signed(64'd1 << f);
    if (v > one) begin
      return one;
    end else if (v < -one) begin
      return -one;
    end
    return v;
  endfunction

endpackage

[rtl/ethtf_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: pose input and transform output, valid/ready.
// Depends on nothing.
interface ethtf_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  modport source(output valid, trans_x, trans_y, trans_z, roll_angle, pitch_angle,
                 yaw_angle, input ready);
  modport sink(input valid, trans_x, trans_y, trans_z, roll_angle, pitch_angle,
               yaw_angle, output ready);
endinterface

interface ethtf_xform_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 out_x, out_y, out_z, input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
               out_x, out_y, out_z, output ready);
endinterface

[rtl/euler_to_homogeneous_transform.sv]
`timescale 1ns / 1ps
// Pose to homogeneous transform: top level joining CORDIC and matrix pipelines.
// Depends on ethtf_pkg, ethtf_if, ethtf_cordic and ethtf_mat.
//
// Usage:
//   pose  (sink)  : three Q16.16 translations and roll / pitch / yaw binary
//                   angles; a transfer happens when valid and ready are high.
//   xform (source): rows 0..2 of the 4x4 transform, R = Rz(yaw)*Ry(roll)*
//                   Rx(pitch) as Q1.14 entries plus the translation column.
// Pipeline from pose transfer to xform valid: 1 fold stage,
//   30 CORDIC stages, 7 rounding / multiply / sum stages.
// Throughput: one pose per cycle; every stage is a register with its own
//   valid bit, so a new pose is taken each cycle while the pipe moves.
// Stall: when the receiver holds ready low, the output register holds its
//   transfer and full stages fill up behind it; empty stages still take
//   data, so bubbles collapse. Nothing is dropped or repeated.
// Reset: rst (synchronous) clears all valid bits; no poses are in flight
//   afterwards. The block keeps no state between poses.
module euler_to_homogeneous_transform #(
  parameter int ANGLE_BITS     = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst,
  ethtf_pose_if.sink    pose,
  ethtf_xform_if.source xform
);
  ethtf_pkg::cordic_res_t res;
  logic                   res_valid;
  logic                   res_ready;

  // Sine / cosine of the three angles, translations carried alongside.
  ethtf_cordic #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .pose     (pose),
    .res      (res),
    .res_valid(res_valid),
    .res_ready(res_ready)
  );

  // Round, multiply and sum into the rotation entries; drive the output.
  ethtf_mat #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mat (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .xform    (xform)
  );
endmodule

[rtl/ethtf_cordic.sv]
`timescale 1ns / 1ps
// Angle fold plus 30-stage CORDIC pipeline, three angles side by side.
// Depends on ethtf_pkg, ethtf_if and euler_to_homogeneous_transform_defines.svh.
`include "euler_to_homogeneous_transform_defines.svh"
module ethtf_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  ethtf_pose_if.sink           pose,
  output ethtf_pkg::cordic_res_t res,
  output logic                 res_valid,
  input  logic                 res_ready
);
  localparam int N  = ethtf_pkg::CORDIC_ITERS;
  localparam int ZW = ethtf_pkg::ZW;

  logic [N:0]   v;
  logic [N+1:0] rdy;

  logic signed [ZW-1:0] xs [0:N][0:2];
  logic signed [ZW-1:0] ys [0:N][0:2];
  logic signed [ZW-1:0] zs [0:N][0:2];
  logic [2:0]           flip [0:N];
  logic [95:0]          tr [0:N];

  logic [15:0]          ang [0:2];
  logic signed [ZW-1:0] z_next [0:2];
  logic [2:0]           flip_next;

  assign ang[0] = pose.roll_angle;
  assign ang[1] = pose.pitch_angle;
  assign ang[2] = pose.yaw_angle;

  assign rdy[N+1]  = res_ready;
  assign pose.ready = rdy[0];

  // Scale to a 32-bit turn, then fold into the half plane around zero.
  always_comb begin
    logic [31:0]          araw;
    logic [31:0]          a32;
    logic signed [ZW-1:0] zi;
    for (int l = 0; l < 3; l++) begin
      araw = {16'd0, ang[l]};
      a32  = araw << (32 - ANGLE_BITS);
      zi   = {{(ZW-32){a32[31]}}, a32};
      if (zi > ethtf_pkg::CORDIC_QUARTER) begin
        z_next[l]    = zi - ethtf_pkg::CORDIC_HALF;
        flip_next[l] = 1'b1;
      end else if (zi < -ethtf_pkg::CORDIC_QUARTER) begin
        z_next[l]    = zi + ethtf_pkg::CORDIC_HALF;
        flip_next[l] = 1'b1;
      end else begin
        z_next[l]    = zi;
        flip_next[l] = 1'b0;
      end
    end
  end

  for (genvar s = 0; s <= N; s++) begin : g_rdy
    assign rdy[s] = !v[s] || rdy[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= pose.valid;
      end
      for (int s = 1; s <= N; s++) begin
        if (rdy[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < 3; l++) begin
        xs[0][l] <= ethtf_pkg::CORDIC_GAIN;
        ys[0][l] <= '0;
        zs[0][l] <= z_next[l];
      end
      flip[0] <= flip_next;
      tr[0]   <= {pose.trans_x, pose.trans_y, pose.trans_z};
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rdy[i+1]) begin
        for (int l = 0; l < 3; l++) begin
          if (!zs[i][l][ZW-1]) begin
            xs[i+1][l] <= xs[i][l] - (ys[i][l] >>> i);
            ys[i+1][l] <= ys[i][l] + (xs[i][l] >>> i);
            zs[i+1][l] <= zs[i][l] - ethtf_pkg::atan_q32(i);
          end else begin
            xs[i+1][l] <= xs[i][l] + (ys[i][l] >>> i);
            ys[i+1][l] <= ys[i][l] - (xs[i][l] >>> i);
            zs[i+1][l] <= zs[i][l] + ethtf_pkg::atan_q32(i);
          end
        end
        flip[i+1] <= flip[i];
        tr[i+1]   <= tr[i];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      res.x[l] = xs[N][l];
      res.y[l] = ys[N][l];
    end
    res.flip    = flip[N];
    res.trans_x = tr[N][95:64];
    res.trans_y = tr[N][63:32];
    res.trans_z = tr[N][31:0];
  end
  assign res_valid = v[N];

  `ETHTF_ASSERT_IMPL(a_fold_range, clk, rst, v[0],
    zs[0][0] <= ethtf_pkg::CORDIC_QUARTER && zs[0][0] >= -ethtf_pkg::CORDIC_QUARTER)
  `ETHTF_ASSERT_IMPL(a_hold_on_stall, clk, rst, v[N] && !res_ready, ##1 v[N])
endmodule

[rtl/ethtf_mat.sv]
`timescale 1ns / 1ps
// Rounding, products and sums that turn sines and cosines into R = Rz*Ry*Rx.
// Depends on ethtf_pkg, ethtf_if and euler_to_homogeneous_transform_defines.svh.
`include "euler_to_homogeneous_transform_defines.svh"
module ethtf_mat #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ethtf_pkg::cordic_res_t res,
  input  logic                  res_valid,
  output logic                  res_ready,
  ethtf_xform_if.source         xform
);
  localparam int F  = COEF_FRAC_BITS;
  localparam int W  = F + 2;
  localparam int P  = 2 * W;
  localparam int ZW = ethtf_pkg::ZW;
  localparam int NS = 7;
  localparam logic signed [W-1:0] ONE = W'(1) << F;

  logic [NS:1]   v;
  logic [NS+1:1] rdy;
  logic [95:0]   tr [1:NS-1];

  // stage 1: sign fold
  logic signed [ZW-1:0] xn1 [0:2];
  logic signed [ZW-1:0] yn1 [0:2];
  // stage 2: rounded cos / sin, lanes roll, pitch, yaw
  logic signed [W-1:0] c2 [0:2];
  logic signed [W-1:0] s2 [0:2];
  // stage 3: products
  logic signed [P-1:0] p3 [0:9];
  logic signed [W-1:0] sr3, sp3, cp3;
  // stage 4
  logic signed [W-1:0] ta4, tb4, sp4, cp4;
  logic signed [P-1:0] q4 [0:3];
  logic [15:0]         f4 [0:4];
  // stage 5
  logic signed [P-1:0] e5 [0:3];
  logic signed [P-1:0] q5 [0:3];
  logic [15:0]         f5 [0:4];
  // stage 6
  logic signed [63:0]  s6 [0:3];
  logic [15:0]         f6 [0:4];

  assign rdy[NS+1]  = xform.ready;
  assign res_ready  = rdy[1];
  assign xform.valid = v[NS];

  for (genvar s = 1; s <= NS; s++) begin : g_rdy
    assign rdy[s] = !v[s] || rdy[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= res_valid;
      end
      for (int s = 2; s <= NS; s++) begin
        if (rdy[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int l = 0; l < 3; l++) begin
        xn1[l] <= res.flip[l] ? -res.x[l] : res.x[l];
        yn1[l] <= res.flip[l] ? -res.y[l] : res.y[l];
      end
      tr[1] <= {res.trans_x, res.trans_y, res.trans_z};
    end
    if (rdy[2]) begin
      for (int l = 0; l < 3; l++) begin
        c2[l] <= W'(ethtf_pkg::sat_coef(ethtf_pkg::round_shift(64'(xn1[l]), 30 - F), F));
        s2[l] <= W'(ethtf_pkg::sat_coef(ethtf_pkg::round_shift(64'(yn1[l]), 30 - F), F));
      end
      tr[2] <= tr[1];
    end
    if (rdy[3]) begin
      p3[0] <= P'(c2[2]) * P'(c2[0]);  // cq*cr
      p3[1] <= P'(c2[2]) * P'(s2[0]);  // cq*sr
      p3[2] <= P'(s2[2]) * P'(s2[0]);  // sq*sr
      p3[3] <= P'(s2[2]) * P'(c2[1]);  // sq*cp
      p3[4] <= P'(s2[2]) * P'(s2[1]);  // sq*sp
      p3[5] <= P'(c2[2]) * P'(c2[1]);  // cq*cp
      p3[6] <= P'(c2[2]) * P'(s2[1]);  // cq*sp
      p3[7] <= P'(c2[0]) * P'(s2[1]);  // cr*sp
      p3[8] <= P'(c2[0]) * P'(c2[1]);  // cr*cp
      p3[9] <= P'(s2[2]) * P'(c2[0]);  // sq*cr
      sr3   <= s2[0];
      sp3   <= s2[1];
      cp3   <= c2[1];
      tr[3] <= tr[2];
    end
    if (rdy[4]) begin
      ta4 <= W'(ethtf_pkg::round_shift(64'(p3[1]), F));
      tb4 <= W'(ethtf_pkg::round_shift(64'(p3[2]), F));
      f4[0] <= 16'(ethtf_pkg::sat_coef(ethtf_pkg::round_shift(64'(p3[0]), F), F));
      f4[1] <= 16'(ethtf_pkg::sat_coef(ethtf_pkg::round_shift(64'(p3[9]), F), F));
      f4[2] <= 16'(ethtf_pkg::sat_coef(-64'(sr3), F));
      f4[3] <= 16'(ethtf_pkg::sat_coef(ethtf_pkg::round_shift(64'(p3[7]), F), F));
      f4[4] <= 16'(ethtf_pkg::sat_coef(ethtf_pkg::round_shift(64'(p3[8]), F), F));
      for (int k = 0; k < 4; k++) begin
        q4[k] <= p3[k+3];
      end
      sp4   <= sp3;
      cp4   <= cp3;
      tr[4] <= tr[3];
    end
    if (rdy[5]) begin
      e5[0] <= P'(ta4) * P'(sp4);
      e5[1] <= P'(ta4) * P'(cp4);
      e5[2] <= P'(tb4) * P'(sp4);
      e5[3] <= P'(tb4) * P'(cp4);
      q5    <= q4;
      f5    <= f4;
      tr[5] <= tr[4];
    end
    if (rdy[6]) begin
      s6[0] <= 64'(e5[0]) - 64'(q5[0]);  // m01
      s6[1] <= 64'(e5[1]) + 64'(q5[1]);  // m02
      s6[2] <= 64'(e5[2]) + 64'(q5[2]);  // m11
      s6[3] <= 64'(e5[3]) - 64'(q5[3]);  // m12
      f6    <= f5;
      tr[6] <= tr[5];
    end
    if (rdy[7]) begin
      xform.m00 <= f6[0];
      xform.m10 <= f6[1];
      xform.m20 <= f6[2];
      xform.m21 <= f6[3];
      xform.m22 <= f6[4];
      xform.m01 <= 16'(ethtf_pkg::sat_coef(ethtf_pkg::round_shift(s6[0], F), F));
      xform.m02 <= 16'(ethtf_pkg::sat_coef(ethtf_pkg::round_shift(s6[1], F), F));
      xform.m11 <= 16'(ethtf_pkg::sat_coef(ethtf_pkg::round_shift(s6[2], F), F));
      xform.m12 <= 16'(ethtf_pkg::sat_coef(ethtf_pkg::round_shift(s6[3], F), F));
      xform.out_x <= tr[6][95:64];
      xform.out_y <= tr[6][63:32];
      xform.out_z <= tr[6][31:0];
    end
  end

  `ETHTF_ASSERT_IMPL(a_coef_sat, clk, rst, v[2], c2[0] <= ONE && c2[0] >= -ONE)
  `ETHTF_ASSERT_IMPL(a_ta_range, clk, rst, v[4], ta4 <= ONE && ta4 >= -ONE)
  `ETHTF_ASSERT_IMPL(a_tb_range, clk, rst, v[4], tb4 <= ONE && tb4 >= -ONE)
endmodule
